@@ rtl/extgcd_pkg.sv @@
// Package for the extended GCD block: operand and coefficient widths, types.
// Depends on nothing; used by extended_gcd_top.
package extgcd_pkg;

    localparam int OPND_W = 32;
    localparam int COEF_W = OPND_W + 1;
    localparam int CNT_W  = $clog2(OPND_W);

    typedef logic [OPND_W-1:0]        opnd_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [CNT_W-1:0]         cnt_t;

endpackage

@@ rtl/extended_gcd_top.sv @@
// Extended Euclidean GCD block: gcd and Bezout coefficients of two operands.
// Depends on extgcd_pkg (widths and types).
//
//  channel | signals                          | direction | handshake
//  --------+----------------------------------+-----------+----------------------
//  in      | a_value, b_value                 | to block  | in_valid / in_ready
//  out     | divisor, coef_a, coef_b          | from block| out_valid / out_ready
//
// Each quotient step runs the divider over every bit of the operand; there are no
// quotient steps for a zero operand and at most 45 for 32-bit operands. The result is
// then written to the output register.
// The steps run on the shared restoring divider: one quotient bit a cycle,
// with the two coefficient products accumulated bit by bit alongside it.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready is held in the output register and a new word may still enter.
// Reset clears state_reg, the bit counter and out_valid; swap and payload registers are not reset.
module extended_gcd_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  extgcd_pkg::opnd_t    a_value,
    input  extgcd_pkg::opnd_t    b_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output extgcd_pkg::opnd_t    divisor,
    output extgcd_pkg::coef_t    coef_a,
    output extgcd_pkg::coef_t    coef_b
);
    import extgcd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam cnt_t CNT_LAST = cnt_t'(OPND_W - 1);

    // Sequencer state
    logic  state_reg, state_next;
    cnt_t  cnt_reg, cnt_next;
    logic  swap_reg, swap_next;

    // Divider: dividend shifting out as quotient shifts in, partial remainder, divisor
    opnd_t quo_reg, quo_next;
    opnd_t rem_reg, rem_next;
    opnd_t div_reg, div_next;

    // Coefficient pairs and the running products q*s1, q*t1
    coef_t s0_reg, s0_next, s1_reg, s1_next;
    coef_t t0_reg, t0_next, t1_reg, t1_next;
    coef_t accs_reg, accs_next, acct_reg, acct_next;

    // Output register
    logic  out_valid_reg, out_valid_next;
    opnd_t divisor_reg, divisor_next;
    coef_t coef_a_reg, coef_a_next, coef_b_reg, coef_b_next;

    // Shared divider step
    logic [OPND_W:0] trial;
    opnd_t           diff;
    logic            ge;
    opnd_t           rem_step;
    coef_t           accs_step, acct_step;

    logic in_fire, out_free, finish;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish    = (state_reg == ST_RUN) && (cnt_reg == '0) && (div_reg == '0);

    always_comb
    begin
        trial     = {rem_reg, quo_reg[OPND_W-1]};
        // Only used when the trial value is not below the divisor, so it fits the width
        diff      = trial[OPND_W-1:0] - div_reg;
        ge        = (trial >= {1'b0, div_reg});
        rem_step  = ge ? diff : trial[OPND_W-1:0];
        accs_step = (accs_reg << 1) + (ge ? s1_reg : '0);
        acct_step = (acct_reg << 1) + (ge ? t1_reg : '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        swap_next      = swap_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        accs_next      = accs_reg;
        acct_next      = acct_reg;
        out_valid_next = out_valid_reg;
        divisor_next   = divisor_reg;
        coef_a_next    = coef_a_reg;
        coef_b_next    = coef_b_reg;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Larger operand goes first; remember to swap the coefficients back
                    swap_next  = (a_value < b_value);
                    quo_next   = (a_value < b_value) ? b_value : a_value;
                    div_next   = (a_value < b_value) ? a_value : b_value;
                    rem_next   = '0;
                    s0_next    = coef_t'(1);
                    s1_next    = '0;
                    t0_next    = '0;
                    t1_next    = coef_t'(1);
                    accs_next  = '0;
                    acct_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        divisor_next   = quo_reg;
                        coef_a_next    = swap_reg ? t0_reg : s0_reg;
                        coef_b_next    = swap_reg ? s0_reg : t0_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else if (cnt_reg == CNT_LAST)
                begin
                    // Last quotient bit: advance the remainder and coefficient sequences
                    quo_next  = div_reg;
                    div_next  = rem_step;
                    rem_next  = '0;
                    s0_next   = s1_reg;
                    s1_next   = s0_reg - accs_step;
                    t0_next   = t1_reg;
                    t1_next   = t0_reg - acct_step;
                    accs_next = '0;
                    acct_next = '0;
                    cnt_next  = '0;
                end
                else
                begin
                    quo_next  = {quo_reg[OPND_W-2:0], ge};
                    rem_next  = rem_step;
                    accs_next = accs_step;
                    acct_next = acct_step;
                    cnt_next  = cnt_reg + cnt_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        swap_reg    <= swap_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        accs_reg    <= accs_next;
        acct_reg    <= acct_next;
        divisor_reg <= divisor_next;
        coef_a_reg  <= coef_a_next;
        coef_b_reg  <= coef_b_next;
    end

    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign coef_a    = coef_a_reg;
    assign coef_b    = coef_b_reg;

    // The divider never runs a bit with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg != '0) |-> (div_reg != '0))
        else $error("divider stepping with zero divisor");

    // Restoring invariant: partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg != '0) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    // The bit counter rests at zero while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("bit counter not cleared in idle");

    // An accepted word starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_RUN))
        else $error("accepted word did not start the sequencer");

    // A pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_RUN) |=> out_valid_reg)
        else $error("pending result lost");

endmodule

@@ test/tb_extended_gcd_top.sv @@
// Testbench for extended_gcd_top: random and corner operand pairs are pushed through the block,
// and every gcd and Bezout coefficient pair is checked against a local Euclid predictor.
// Depends on extgcd_pkg (operand and coefficient types) and rtl/extended_gcd_top.sv.
module tb_extended_gcd_top;

    timeunit 1ns;
    timeprecision 1ps;

    import extgcd_pkg::*;

    // Allow for the slowest legal word, for stalls and for the long hold-off
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int RANDOM_WORDS  = 1030;
    localparam int HOLD_CYCLES   = 4000;
    localparam int DRAIN_CYCLES  = 200;

    typedef struct packed {
        opnd_t a;
        opnd_t b;
    } pair_t;

    typedef struct packed {
        opnd_t gcd;
        coef_t ca;
        coef_t cb;
    } bezout_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    opnd_t a_value   = '0;
    opnd_t b_value   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    opnd_t divisor;
    coef_t coef_a;
    coef_t coef_b;

    pair_t   pairs_pending[$];
    bezout_t bezout_due[$];

    bit in_taken      = 1'b0;
    bit rx_hold       = 1'b0;
    int words_total   = 0;
    int words_in      = 0;
    int words_out     = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 8;
    int recv_idle_pct = 54;

    extended_gcd_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_value   (a_value),
        .b_value   (b_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .divisor   (divisor),
        .coef_a    (coef_a),
        .coef_b    (coef_b)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Euclid on the larger operand first, coefficients carried modulo 2^64 and swapped
    // back to the caller's order. The true values sit well inside 64 bits, so the wrap is exact.
    function automatic bezout_t predict_bezout(opnd_t a, opnd_t b);
        logic [63:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
        logic        swapped;
        bezout_t     res;
        swapped = (a < b);
        r0 = swapped ? b : a;
        r1 = swapped ? a : b;
        s0 = 64'd1;
        s1 = 64'd0;
        t0 = 64'd0;
        t1 = 64'd1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - q * s1;
            tn = t0 - q * t1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
            t0 = t1;
            t1 = tn;
        end
        res.gcd = r0[OPND_W-1:0];
        res.ca  = swapped ? t0[COEF_W-1:0] : s0[COEF_W-1:0];
        res.cb  = swapped ? s0[COEF_W-1:0] : t0[COEF_W-1:0];
        return res;
    endfunction

    task automatic queue_pair(opnd_t a, opnd_t b);
        pair_t p;
        p.a = a;
        p.b = b;
        pairs_pending.push_back(p);
        words_total++;
    endtask

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch on result word %0d: %s", $realtime, words_out, what);
        mismatches++;
    endtask

    // Idling profile follows how far the run has got: sender eager and receiver busy first,
    // then the other way round, then both flat out.
    always @(negedge clk)
    begin
        if (words_in < 350)
        begin
            send_idle_pct <= 8;
            recv_idle_pct <= 54;
        end
        else if (words_in < 700)
        begin
            send_idle_pct <= 54;
            recv_idle_pct <= 8;
        end
        else
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    end

    // Driver: hold the word until it is taken, then offer the next one or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pairs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                a_value  <= pairs_pending[0].a;
                b_value  <= pairs_pending[0].b;
                void'(pairs_pending.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, forced low for the whole of the hold-off
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold the output side off for a long stretch while words keep being offered,
    // so the result register and the sequencer both fill and in_ready drops.
    initial
    begin
        while (words_in < 100)
            @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: predict on every accepted word, check every accepted result against the oldest
    always @(posedge clk)
    begin
        bezout_t got;
        bezout_t want;
        in_taken = in_valid && in_ready;
        if (in_taken)
        begin
            bezout_due.push_back(predict_bezout(a_value, b_value));
            words_in++;
        end
        if (out_valid && out_ready)
        begin
            got.gcd = divisor;
            got.ca  = coef_a;
            got.cb  = coef_b;
            if (bezout_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result gcd=%0h", got.gcd));
            end
            else
            begin
                want = bezout_due.pop_front();
                if (got.gcd !== want.gcd)
                    flag_mismatch($sformatf("divisor %0h, want %0h", got.gcd, want.gcd));
                if (got.ca !== want.ca)
                    flag_mismatch($sformatf("coef_a %0d, want %0d", got.ca, want.ca));
                if (got.cb !== want.cb)
                    flag_mismatch($sformatf("coef_b %0d, want %0d", got.cb, want.cb));
            end
            words_out++;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** extended_gcd_top: FAILED **");
        $finish;
    end

    initial
    begin
        opnd_t       fib[0:47];
        int unsigned sel;
        int unsigned k;
        int unsigned g;
        opnd_t       x;
        opnd_t       y;

        fib[0] = '0;
        fib[1] = 1;
        for (int i = 2; i < 48; i++)
            fib[i] = fib[i-1] + fib[i-2];

        // Corner words: zeros, equal operands, swapped order, extremes and the longest chain
        queue_pair(32'd0, 32'd0);
        queue_pair(32'd12345, 32'd0);
        queue_pair(32'hFFFF_FFFF, 32'd0);
        queue_pair(32'd0, 32'd98765);
        queue_pair(32'd0, 32'hFFFF_FFFF);
        queue_pair(32'd77, 32'd77);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pair(32'd1, 32'd1);
        queue_pair(32'hFFFF_FFFF, 32'd1);
        queue_pair(32'd1, 32'hFFFF_FFFF);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_pair(32'd240, 32'd46);
        queue_pair(32'd46, 32'd240);
        queue_pair(fib[47], fib[46]);
        queue_pair(fib[46], fib[47]);
        queue_pair(32'h8000_0000, 32'h4000_0000);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF);
        queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
        queue_pair(32'h5555_5555, 32'hAAAA_AAAA);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (sel < 75)
            begin
                // shared factor, so the gcd is rarely one
                g = $urandom_range(65535, 1);
                x = opnd_t'(g * $urandom_range(65535, 0));
                y = opnd_t'(g * $urandom_range(65535, 0));
            end
            else if (sel < 85)
            begin
                x = $urandom_range(255, 0);
                y = $urandom_range(255, 0);
            end
            else if (sel < 90)
            begin
                x = $urandom;
                y = '0;
                if ($urandom_range(1))
                begin
                    y = x;
                    x = '0;
                end
            end
            else if (sel < 94)
            begin
                x = $urandom;
                y = x;
            end
            else
            begin
                // neighbouring Fibonacci numbers: the most quotient steps for their size
                k = $urandom_range(46, 1);
                x = fib[k+1];
                y = fib[k];
                if ($urandom_range(1))
                begin
                    x = fib[k];
                    y = fib[k+1];
                end
            end
            queue_pair(x, y);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_in < words_total || bezout_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** extended_gcd_top: PASSED **");
        else
            $display("** extended_gcd_top: FAILED **");
        $finish;
    end

endmodule
